/* hw/rtl/lth_pkg.sv */
`timescale 1ns / 1ps

package lth_pkg;

  typedef logic [1:0] mode_t;

  localparam mode_t MODE_INACTIVE = 2'd0;
  localparam mode_t MODE_TAPPING  = 2'd1;
  localparam mode_t MODE_HOLDING  = 2'd2;
  localparam mode_t MODE_TOGGLED  = 2'd3;

  typedef logic [2:0] op_t;

  localparam op_t OP_TICK  = 3'd0;
  localparam op_t OP_LAYER = 3'd1;
  localparam op_t OP_OTHER = 3'd2;
  localparam op_t OP_LOCK  = 3'd3;
  localparam op_t OP_BASE  = 3'd4;

  localparam int unsigned IN_DATA_W  = 32;
  localparam int unsigned OUT_DATA_W = 32;
  localparam int unsigned ADDR_W     = 3;

  localparam logic [15:0] TAP_TERM_RESET = 16'd200;

endpackage

/* hw/rtl/layer_tap_hold_toggle.sv */
`timescale 1ns / 1ps

// Tap/hold/lock control of keyboard layers. Each accepted input item (a tick,
// a layer key, another key, a lock key or a base key; op travels in s_tuser)
// updates the per-layer modes, the press timestamps, the millisecond counter
// and the layer mask in the cycle it is accepted, and its single result
// (tap request, layer mask, top layer) appears in the output register on the
// next cycle. One item is taken every cycle: all layers are evaluated in
// parallel by one pass of logic between the state registers and the output
// register, and the only stall comes from a full output register that the
// downstream side does not take. tap_term_ms sits at APB byte address 0; write
// it only while no item is in flight.
module layer_tap_hold_toggle #(
  parameter int LAYER_COUNT = 8
) (
  input  logic                              clk,
  input  logic                              rst,
  // APB configuration
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [lth_pkg::ADDR_W-1:0]        paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready,
  // input items
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // fields from bit 0: pressed, layer[3], alt_layer[3], alt_held, key_code[16],
  // is_shift, zero fill
  input  logic [lth_pkg::IN_DATA_W-1:0]     s_tdata,
  // fields from bit 0: op[3]
  input  logic [2:0]                        s_tuser,
  // result items
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // fields from bit 0: tap_valid, tap_code[16], layer_mask[8], top_layer[3],
  // zero fill
  output logic [lth_pkg::OUT_DATA_W-1:0]    m_tdata
);

  import lth_pkg::*;

  localparam int LW = (LAYER_COUNT > 1) ? $clog2(LAYER_COUNT) : 1;
  localparam int CW = (LW > 3) ? LW : 3;
  localparam int MW = (LAYER_COUNT < 8) ? LAYER_COUNT : 8;

  // configuration
  logic [15:0] tap_term_ms;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      tap_term_ms <= TAP_TERM_RESET;
    end else if (psel && penable && pwrite && pready && !paddr[2]) begin
      tap_term_ms <= pwdata[15:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (!paddr[2]) begin
      prdata = {16'd0, tap_term_ms};
    end
  end

  // input fields
  logic        in_pressed;
  logic [2:0]  in_layer;
  logic [2:0]  in_alt_layer;
  logic        in_alt_held;
  logic [15:0] in_key_code;
  logic        in_is_shift;
  op_t         in_op;

  assign in_pressed   = s_tdata[0];
  assign in_layer     = s_tdata[3:1];
  assign in_alt_layer = s_tdata[6:4];
  assign in_alt_held  = s_tdata[7];
  assign in_key_code  = s_tdata[23:8];
  assign in_is_shift  = s_tdata[24];
  assign in_op        = s_tuser;

  // state
  logic [15:0]            now_ms;
  logic [15:0]            press_time [LAYER_COUNT];
  mode_t                  layer_mode [LAYER_COUNT];
  logic [LAYER_COUNT-1:0] active_mask;
  logic [15:0]            saved_tap_code;

  logic [15:0]            now_ms_next;
  logic [15:0]            press_time_next [LAYER_COUNT];
  mode_t                  layer_mode_next [LAYER_COUNT];
  logic [LAYER_COUNT-1:0] active_mask_next;
  logic [15:0]            saved_tap_code_next;

  logic                   tap;
  logic [15:0]            tap_code;

  function automatic logic [LW-1:0] highest(input logic [LAYER_COUNT-1:0] m);
    logic [LW-1:0] top;
    top = '0;
    for (int l = 0; l < LAYER_COUNT; l++) begin
      if (m[l]) begin
        top = LW'(l);
      end
    end
    return top;
  endfunction

  logic [LW-1:0] top_cur;
  logic [CW-1:0] top_cur_ext;
  logic [CW-1:0] alt_ext;
  logic [2:0]    target;
  logic [CW-1:0] target_ext;

  assign top_cur     = highest(active_mask);
  assign top_cur_ext = CW'(top_cur);
  assign alt_ext     = CW'(in_alt_layer);

  always_comb begin
    if (in_pressed) begin
      target = in_alt_held ? in_alt_layer : in_layer;
    end else begin
      target = (top_cur_ext == alt_ext) ? in_alt_layer : in_layer;
    end
  end

  assign target_ext = CW'(target);

  always_comb begin
    now_ms_next         = now_ms;
    press_time_next     = press_time;
    layer_mode_next     = layer_mode;
    active_mask_next    = active_mask;
    saved_tap_code_next = saved_tap_code;
    tap                 = 1'b0;
    tap_code            = '0;

    unique case (in_op)
      OP_TICK: begin
        now_ms_next = now_ms + 16'd1;
        for (int l = 0; l < LAYER_COUNT; l++) begin
          if (layer_mode[l] == MODE_TAPPING &&
              16'(now_ms_next - press_time[l]) > tap_term_ms) begin
            layer_mode_next[l] = MODE_HOLDING;
          end
        end
      end
      OP_LAYER: begin
        // a target at or beyond the layer count matches no lane
        for (int l = 0; l < LAYER_COUNT; l++) begin
          if (target_ext == CW'(l)) begin
            if (in_pressed) begin
              press_time_next[l] = now_ms;
              if (layer_mode[l] == MODE_INACTIVE) begin
                layer_mode_next[l]  = MODE_TAPPING;
                saved_tap_code_next = in_key_code;
                active_mask_next[l] = 1'b1;
              end else if (layer_mode[l] == MODE_TOGGLED) begin
                layer_mode_next[l]  = MODE_INACTIVE;
                active_mask_next[l] = 1'b0;
              end
            end else begin
              if (layer_mode[l] == MODE_TAPPING) begin
                tap                 = 1'b1;
                tap_code            = in_key_code;
                layer_mode_next[l]  = MODE_INACTIVE;
                active_mask_next[l] = 1'b0;
              end else if (layer_mode[l] == MODE_HOLDING) begin
                layer_mode_next[l]  = MODE_INACTIVE;
                active_mask_next[l] = 1'b0;
              end
            end
          end
        end
      end
      OP_OTHER: begin
        for (int l = 0; l < LAYER_COUNT; l++) begin
          if (top_cur == LW'(l) && layer_mode[l] == MODE_TAPPING) begin
            if (in_pressed) begin
              layer_mode_next[l] = MODE_HOLDING;
            end else if (in_is_shift) begin
              // rolling shift: send the saved code and drop the layer
              tap                 = 1'b1;
              tap_code            = saved_tap_code;
              layer_mode_next[l]  = MODE_INACTIVE;
              active_mask_next[l] = 1'b0;
            end
          end
        end
      end
      OP_LOCK: begin
        for (int l = 0; l < LAYER_COUNT; l++) begin
          if (in_pressed && top_cur == LW'(l)) begin
            if (layer_mode[l] == MODE_TAPPING || layer_mode[l] == MODE_HOLDING) begin
              layer_mode_next[l] = MODE_TOGGLED;
            end else if (layer_mode[l] == MODE_TOGGLED) begin
              layer_mode_next[l]  = MODE_INACTIVE;
              active_mask_next[l] = 1'b0;
            end
          end
        end
      end
      OP_BASE: begin
        for (int l = 0; l < LAYER_COUNT; l++) begin
          layer_mode_next[l] = MODE_INACTIVE;
        end
        active_mask_next = '0;
      end
      default: begin
      end
    endcase
  end

  logic [LW-1:0] top_next;
  logic [CW-1:0] top_next_ext;
  logic [7:0]    mask_out;

  assign top_next     = highest(active_mask_next);
  assign top_next_ext = CW'(top_next);
  assign mask_out     = 8'(active_mask_next[MW-1:0]);

  logic accept;

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      now_ms         <= '0;
      active_mask    <= '0;
      saved_tap_code <= '0;
      for (int l = 0; l < LAYER_COUNT; l++) begin
        layer_mode[l] <= MODE_INACTIVE;
      end
    end else if (accept) begin
      now_ms         <= now_ms_next;
      active_mask    <= active_mask_next;
      saved_tap_code <= saved_tap_code_next;
      layer_mode     <= layer_mode_next;
    end
  end

  // timestamps are read only in the tapping mode, which a press always writes
  always_ff @(posedge clk) begin
    if (accept) begin
      press_time <= press_time_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_tdata <= {4'd0, top_next_ext[2:0], mask_out, tap_code, tap};
    end
  end

  // assertions
  logic [LAYER_COUNT-1:0] mode_active;

  always_comb begin
    for (int l = 0; l < LAYER_COUNT; l++) begin
      mode_active[l] = (layer_mode[l] != MODE_INACTIVE);
    end
  end

  a_mask_matches_modes: assert property (@(posedge clk) disable iff (rst)
    active_mask == mode_active)
    else $error("layer mask disagrees with layer modes");

  a_no_code_without_tap: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tdata[0]) |-> (m_tdata[16:1] == 16'd0))
    else $error("tap code set without tap");

  a_base_clears: assert property (@(posedge clk) disable iff (rst)
    (accept && in_op == OP_BASE) |=> (active_mask == '0 && m_tvalid && m_tdata[24:17] == 8'd0))
    else $error("base key left a layer active");

  a_tick_advances: assert property (@(posedge clk) disable iff (rst)
    (accept && in_op == OP_TICK) |=> (now_ms == 16'($past(now_ms) + 16'd1)))
    else $error("tick did not advance the counter");

  a_non_tick_holds: assert property (@(posedge clk) disable iff (rst)
    (accept && in_op != OP_TICK) |=> $stable(now_ms))
    else $error("counter moved without a tick");

endmodule
